@@ hw/rtl/btrt_pkg.sv @@
`default_nettype none

package btrt_pkg;

  localparam int unsigned NUM_KEYS    = 4096;
  localparam int unsigned ID_WIDTH    = 20;
  localparam int unsigned EPOCH_WIDTH = 24;
  localparam int unsigned KEY_WIDTH   = 12;
  localparam int unsigned OP_WIDTH    = 2;
  // NUM_KEYS is a power of two, so the key is reduced by dropping high bits.
  localparam int unsigned ADDR_WIDTH  = $clog2(NUM_KEYS);

  localparam logic [EPOCH_WIDTH-1:0] EPOCH_RESET = EPOCH_WIDTH'(1);

  typedef enum logic [OP_WIDTH-1:0] {
    OP_RSV_READ  = 2'd0,
    OP_RSV_WRITE = 2'd1,
    OP_CHK_READ  = 2'd2,
    OP_CHK_WRITE = 2'd3
  } op_e;

  typedef struct packed {
    logic [EPOCH_WIDTH-1:0] epoch;
    logic [ID_WIDTH-1:0]    rts;
    logic [ID_WIDTH-1:0]    wts;
  } entry_t;

  typedef struct packed {
    logic reserved;
    logic raw;
    logic waw;
    logic war;
  } res_t;

  // A held id wins over a new id when it is non-zero and lower.
  function automatic logic beats(logic [ID_WIDTH-1:0] held, logic [ID_WIDTH-1:0] id);
    return (held != '0) && (held < id);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/btrt_update.sv @@
`default_nettype none

module btrt_update (
  input  btrt_pkg::op_e                         op_i,
  input  logic [btrt_pkg::ID_WIDTH-1:0]         txn_id_i,
  input  logic [btrt_pkg::EPOCH_WIDTH-1:0]      cur_epoch_i,
  input  btrt_pkg::entry_t                      entry_i,
  output btrt_pkg::entry_t                      entry_o,
  output logic                                  we_o,
  output btrt_pkg::res_t                        res_o
);
  import btrt_pkg::*;

  logic is_write;
  logic is_reserve;
  logic stale;
  logic epoch_match;
  logic slot_held;

  assign is_write    = (op_i == OP_RSV_WRITE);
  assign is_reserve  = (op_i == OP_RSV_READ) || (op_i == OP_RSV_WRITE);
  assign stale       = (cur_epoch_i > entry_i.epoch);
  assign epoch_match = (entry_i.epoch == cur_epoch_i);
  assign slot_held   = is_write ? beats(entry_i.wts, txn_id_i) : beats(entry_i.rts, txn_id_i);

  always_comb begin
    entry_o = entry_i;
    we_o    = 1'b0;
    res_o   = '0;
    if (is_reserve) begin
      if (txn_id_i != '0) begin
        if (stale) begin
          // A stale entry is replaced as a whole.
          entry_o.epoch = cur_epoch_i;
          entry_o.rts   = is_write ? '0 : txn_id_i;
          entry_o.wts   = is_write ? txn_id_i : '0;
          we_o          = 1'b1;
          res_o.reserved = 1'b1;
        end else if (!slot_held) begin
          entry_o.epoch = cur_epoch_i;
          if (is_write) begin
            entry_o.wts = txn_id_i;
          end else begin
            entry_o.rts = txn_id_i;
          end
          we_o           = 1'b1;
          res_o.reserved = 1'b1;
        end
      end
    end else if (epoch_match) begin
      res_o.raw = (op_i == OP_CHK_READ)  && beats(entry_i.wts, txn_id_i);
      res_o.waw = (op_i == OP_CHK_WRITE) && beats(entry_i.wts, txn_id_i);
      res_o.war = (op_i == OP_CHK_WRITE) && beats(entry_i.rts, txn_id_i);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/batch_txn_reservation_table.sv @@
`default_nettype none

// Reservation table for deterministic batch transactions, one entry per key.
// Command channel: an item (op_i, key_i, txn_id_i) is taken at a rising edge
// where start_i is high and busy_o is low. Reserve ops try to install the id
// in the entry's read or write slot; check ops report conflicts against lower
// ids reserved in the current epoch.
// Result channel: done_o is high for exactly one cycle and qualifies
// reserved_o and the three conflict flags. The receiver cannot stall; every
// result is taken at the edge that ends its strobe cycle.
// The accepting edge registers the entry read and enters the update state;
// done_o is then registered from the update state. A new item is taken only
// after the last has had its registered read, update and entry write-back.
// The user must write the epoch register (cfg_we_i/cfg_wdata_i) only while
// idle; the block does not enforce it. Reset sets the epoch register to 1,
// then all 4096 entries are cleared, one per cycle, with busy_o held high.
module batch_txn_reservation_table (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic [btrt_pkg::OP_WIDTH-1:0]          op_i,
  input  logic [btrt_pkg::KEY_WIDTH-1:0]         key_i,
  input  logic [btrt_pkg::ID_WIDTH-1:0]          txn_id_i,
  input  logic                                   cfg_we_i,
  input  logic [btrt_pkg::EPOCH_WIDTH-1:0]       cfg_wdata_i,
  output logic                                   done_o,
  output logic                                   reserved_o,
  output logic                                   raw_conflict_o,
  output logic                                   waw_conflict_o,
  output logic                                   war_conflict_o
);
  import btrt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [ADDR_WIDTH-1:0]   clr_q, clr_d;
  logic [EPOCH_WIDTH-1:0]  epoch_q, epoch_d;
  logic [ADDR_WIDTH-1:0]   addr_q;
  op_e                     op_q;
  logic [ID_WIDTH-1:0]     id_q;
  logic                    done_q, done_d;
  res_t                    res_q;

  entry_t                  mem [NUM_KEYS];
  entry_t                  rdata_q;
  logic                    accept;
  logic                    clr_last;
  logic                    mem_we;
  logic [ADDR_WIDTH-1:0]   mem_waddr;
  entry_t                  mem_wdata;
  entry_t                  upd_entry;
  logic                    upd_we;
  res_t                    upd_res;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign clr_last = (clr_q == ADDR_WIDTH'(NUM_KEYS - 1));

  btrt_update u_update (
    .op_i        (op_q),
    .txn_id_i    (id_q),
    .cur_epoch_i (epoch_q),
    .entry_i     (rdata_q),
    .entry_o     (upd_entry),
    .we_o        (upd_we),
    .res_o       (upd_res)
  );

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    done_d  = 1'b0;
    epoch_d = cfg_we_i ? cfg_wdata_i : epoch_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = (state_q == ST_EXEC) && upd_we;
      mem_waddr = addr_q;
      mem_wdata = upd_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      epoch_q <= EPOCH_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      epoch_q <= epoch_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= key_i[ADDR_WIDTH-1:0];
      op_q   <= op_e'(op_i);
      id_q   <= txn_id_i;
    end
    if (state_q == ST_EXEC) begin
      res_q <= upd_res;
    end
  end

  // Entry memory: one write port, one registered read port. Items are handled
  // one at a time, so a read never overlaps a pending write of the same entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata_q <= mem[key_i[ADDR_WIDTH-1:0]];
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign reserved_o     = res_q.reserved;
  assign raw_conflict_o = res_q.raw;
  assign waw_conflict_o = res_q.waw;
  assign war_conflict_o = res_q.war;

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_EXEC))
    else $error("result strobe without a preceding update cycle");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC) && !done_q)
    else $error("accepted item did not enter the update cycle");

  a_exec_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> done_q && (state_q == ST_IDLE))
    else $error("update cycle did not produce exactly one result");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(res_q.reserved && (res_q.raw || res_q.waw || res_q.war))
               && !(res_q.raw && (res_q.waw || res_q.war)))
    else $error("result flags from different op classes set together");

  a_clear_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && !clr_last |=> (state_q == ST_CLEAR) && busy_o)
    else $error("clearing pass left before the last entry");

endmodule

`default_nettype wire

@@ dv/tb_batch_txn_reservation_table.sv @@
module tb_batch_txn_reservation_table;
  import btrt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned NUM_DIRECTED = 24;
  localparam logic [ID_WIDTH-1:0]    ID_MAX    = '1;
  localparam logic [EPOCH_WIDTH-1:0] EPOCH_MAX = '1;

  typedef struct {
    op_e                 op;
    logic [KEY_WIDTH-1:0] key;
    logic [ID_WIDTH-1:0]  id;
    bit                   typed;
    res_t                 res;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic [OP_WIDTH-1:0]    op_i;
  logic [KEY_WIDTH-1:0]   key_i;
  logic [ID_WIDTH-1:0]    txn_id_i;
  logic                   cfg_we_i;
  logic [EPOCH_WIDTH-1:0] cfg_wdata_i;
  logic                   done_o;
  logic                   reserved_o;
  logic                   raw_conflict_o;
  logic                   waw_conflict_o;
  logic                   war_conflict_o;

  entry_t                 resv_mirror [NUM_KEYS];
  logic [EPOCH_WIDTH-1:0] epoch_mirror;
  res_t                   pending_results [$];
  int unsigned            idle_pct;
  int unsigned            fail_count;

  batch_txn_reservation_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .key_i          (key_i),
    .txn_id_i       (txn_id_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .reserved_o     (reserved_o),
    .raw_conflict_o (raw_conflict_o),
    .waw_conflict_o (waw_conflict_o),
    .war_conflict_o (war_conflict_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic lower_id_holds(logic [ID_WIDTH-1:0] held,
                                          logic [ID_WIDTH-1:0] id);
    return (held != '0) && (held < id);
  endfunction

  // Applies one access to the mirrored table and returns the flags it yields.
  function automatic res_t predict_access(op_e op, logic [KEY_WIDTH-1:0] key,
                                          logic [ID_WIDTH-1:0] id);
    res_t                r;
    entry_t              ent;
    logic                is_write;
    logic [ID_WIDTH-1:0] held;
    r = '0;
    ent = resv_mirror[key % NUM_KEYS];
    is_write = (op == OP_RSV_WRITE);
    case (op)
      OP_RSV_READ, OP_RSV_WRITE: begin
        held = is_write ? ent.wts : ent.rts;
        if (id != '0) begin
          if (epoch_mirror > ent.epoch) begin
            ent.epoch = epoch_mirror;
            ent.rts = is_write ? '0 : id;
            ent.wts = is_write ? id : '0;
            r.reserved = 1'b1;
          end else if (!lower_id_holds(held, id)) begin
            ent.epoch = epoch_mirror;
            if (is_write) ent.wts = id;
            else ent.rts = id;
            r.reserved = 1'b1;
          end
        end
      end
      default: begin
        if (ent.epoch == epoch_mirror) begin
          if (op == OP_CHK_READ) begin
            r.raw = lower_id_holds(ent.wts, id);
          end else begin
            r.waw = lower_id_holds(ent.wts, id);
            r.war = lower_id_holds(ent.rts, id);
          end
        end
      end
    endcase
    resv_mirror[key % NUM_KEYS] = ent;
    return r;
  endfunction

  // Entered and left at a falling edge; start_i stays high after acceptance.
  task automatic issue_item(op_e op, logic [KEY_WIDTH-1:0] key,
                            logic [ID_WIDTH-1:0] id, bit typed, res_t typed_res);
    res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i  <= 1'b1;
    op_i     <= op;
    key_i    <= key;
    txn_id_i <= id;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pred = predict_access(op, key, id);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_epoch(logic [EPOCH_WIDTH-1:0] value);
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    epoch_mirror = value;
  endtask

  task automatic check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none actual done=%b",
                 $time, done_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_flag("reserved", want.reserved, reserved_o);
        check_flag("raw_conflict", want.raw, raw_conflict_o);
        check_flag("waw_conflict", want.waw, waw_conflict_o);
        check_flag("war_conflict", want.war, war_conflict_o);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("** batch_txn_reservation_table: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t              dir_rows [NUM_DIRECTED];
    logic [EPOCH_WIDTH-1:0] phase_epoch [NUM_PHASES];
    op_e                    op;
    logic [KEY_WIDTH-1:0]   key;
    logic [ID_WIDTH-1:0]    id;
    int unsigned            pick;

    start_i     = 1'b0;
    op_i        = '0;
    key_i       = '0;
    txn_id_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    fail_count  = 0;
    idle_pct    = 21;
    epoch_mirror = EPOCH_RESET;
    foreach (resv_mirror[i]) resv_mirror[i] = '0;

    // Rows with typed flags can be read straight off the rules: a cleared
    // store, zero ids and fresh entries. The rest rely on the mirror.
    dir_rows = '{
      '{OP_CHK_READ,  12'd0,    20'd5,     1'b1, 4'b0000},
      '{OP_CHK_WRITE, 12'hFFF,  ID_MAX,    1'b1, 4'b0000},
      '{OP_RSV_READ,  12'd0,    20'd0,     1'b1, 4'b0000},
      '{OP_RSV_READ,  12'd0,    20'd10,    1'b1, 4'b1000},
      '{OP_RSV_READ,  12'd0,    20'd12,    1'b0, 4'b0000},
      '{OP_RSV_READ,  12'd0,    20'd10,    1'b0, 4'b0000},
      '{OP_RSV_READ,  12'd0,    20'd3,     1'b0, 4'b0000},
      '{OP_RSV_WRITE, 12'd0,    20'd7,     1'b0, 4'b0000},
      '{OP_CHK_READ,  12'd0,    20'd9,     1'b0, 4'b0000},
      '{OP_CHK_READ,  12'd0,    20'd7,     1'b0, 4'b0000},
      '{OP_CHK_WRITE, 12'd0,    20'd9,     1'b0, 4'b0000},
      '{OP_CHK_WRITE, 12'd0,    20'd5,     1'b0, 4'b0000},
      '{OP_CHK_WRITE, 12'd0,    20'd0,     1'b1, 4'b0000},
      '{OP_CHK_READ,  12'd0,    20'd0,     1'b1, 4'b0000},
      '{OP_RSV_WRITE, 12'hFFF,  ID_MAX,    1'b1, 4'b1000},
      '{OP_RSV_WRITE, 12'hFFF,  20'd1,     1'b0, 4'b0000},
      '{OP_CHK_WRITE, 12'hFFF,  ID_MAX,    1'b0, 4'b0000},
      '{OP_RSV_WRITE, 12'hFFF,  20'd0,     1'b1, 4'b0000},
      '{OP_RSV_READ,  12'hFFF,  20'd1,     1'b0, 4'b0000},
      '{OP_CHK_WRITE, 12'hFFF,  20'd2,     1'b0, 4'b0000},
      '{OP_CHK_READ,  12'hAAA,  20'h55555, 1'b1, 4'b0000},
      '{OP_RSV_WRITE, 12'h555,  20'hAAAAA, 1'b1, 4'b1000},
      '{OP_RSV_READ,  12'hAAA,  20'h55555, 1'b1, 4'b1000},
      '{OP_CHK_WRITE, 12'hAAA,  20'hAAAAA, 1'b0, 4'b0000}
    };

    // Lowering the epoch leaves entries newer than the current one, and an
    // epoch of zero makes nothing stale.
    phase_epoch[0] = 24'd2;
    phase_epoch[1] = 24'd3;
    phase_epoch[2] = EPOCH_MAX;
    phase_epoch[3] = 24'd9;
    phase_epoch[4] = 24'd0;
    phase_epoch[5] = EPOCH_WIDTH'($urandom_range(10, 24'hFFFFFD));
    phase_epoch[6] = EPOCH_MAX - 24'd1;
    phase_epoch[7] = EPOCH_MAX;
    phase_epoch[8] = 24'd1;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      issue_item(dir_rows[r].op, dir_rows[r].key, dir_rows[r].id,
                 dir_rows[r].typed, dir_rows[r].res);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = (p < 3) ? 21 : (p < 6) ? 66 : 0;
      set_epoch(phase_epoch[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = op_e'($urandom_range(3));
        // A small pool of keys and ids keeps entries contended so that
        // reservations and conflicts actually meet.
        pick = $urandom_range(99);
        if (pick < 70) key = KEY_WIDTH'($urandom_range(15));
        else if (pick < 85) key = KEY_WIDTH'(12'hFF0 + $urandom_range(15));
        else key = KEY_WIDTH'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 5) id = '0;
        else if (pick < 75) id = ID_WIDTH'($urandom_range(1, 24));
        else if (pick < 85) id = ID_MAX - ID_WIDTH'($urandom_range(3));
        else id = ID_WIDTH'($urandom_range(0, 20'hFFFFF));
        issue_item(op, key, id, 1'b0, '0);
      end
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** batch_txn_reservation_table: PASSED **");
    end else begin
      $display("** batch_txn_reservation_table: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/btrt_pkg.sv
hw/rtl/btrt_update.sv
hw/rtl/batch_txn_reservation_table.sv
dv/tb_batch_txn_reservation_table.sv
